### hw/rtl/hclt_pkg.sv
// Shared types and constants for the Huffman code lookup table.
package hclt_pkg;

    localparam int CODE_W   = 16;
    localparam int LEN_W    = 5;
    localparam int SYM_W    = 8;
    localparam int ENTRY_W  = 1 + LEN_W + SYM_W;

    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_FIND = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        logic clr;
        logic take;
        logic rd_find;
        logic rd_first;
        logic fill;
        logic res_find;
        logic res_fail;
        logic res_ok;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic len_ok;
        logic hit;
        logic fill_last;
        logic out_free;
    } t_sts;

endpackage

### hw/rtl/hclt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hclt_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/hclt_dp.sv
// Datapath: request registers, fill counters, table memory and result register.
module hclt_dp #(
    parameter int WINDOW_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hclt_pkg::t_cmd                i_cmd,
    output hclt_pkg::t_sts                o_sts,
    input  logic [hclt_pkg::CODE_W-1:0]   i_code,
    input  logic [hclt_pkg::LEN_W-1:0]    i_code_length,
    input  logic [hclt_pkg::SYM_W-1:0]    i_symbol,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_status,
    output logic [hclt_pkg::LEN_W-1:0]    o_matched_length,
    output logic [hclt_pkg::SYM_W-1:0]    o_matched_symbol
);

    localparam int DEPTH = 1 << WINDOW_BITS;

    logic [WINDOW_BITS-1:0]           r_clr_cnt;
    logic [WINDOW_BITS-1:0]           r_cnt;
    logic [WINDOW_BITS-1:0]           r_base;
    logic [WINDOW_BITS-1:0]           r_mask;
    logic [WINDOW_BITS-1:0]           r_find_idx;
    logic                             r_len_ok;
    logic [hclt_pkg::LEN_W-1:0]       r_len;
    logic [hclt_pkg::SYM_W-1:0]       r_sym;

    logic                             r_pend_status;
    logic [hclt_pkg::LEN_W-1:0]       r_pend_len;
    logic [hclt_pkg::SYM_W-1:0]       r_pend_sym;

    logic                             r_out_valid;
    logic                             r_out_status;
    logic [hclt_pkg::LEN_W-1:0]       r_out_len;
    logic [hclt_pkg::SYM_W-1:0]       r_out_sym;

    logic [hclt_pkg::LEN_W-1:0]       n_fill;
    logic                             n_len_ok;
    logic [WINDOW_BITS-1:0]           n_base;
    logic [WINDOW_BITS-1:0]           n_mask;

    logic                             we;
    logic [WINDOW_BITS-1:0]           waddr;
    logic [hclt_pkg::ENTRY_W-1:0]     wdata;
    logic [WINDOW_BITS-1:0]           raddr;
    logic [hclt_pkg::ENTRY_W-1:0]     rdata;

    // Fill geometry is worked out from the request as it is taken.
    always_comb begin
        n_len_ok = (i_code_length != '0) &&
                   (i_code_length <= hclt_pkg::LEN_W'(WINDOW_BITS));
        n_fill   = hclt_pkg::LEN_W'(WINDOW_BITS) - i_code_length;
        n_base   = WINDOW_BITS'({16'd0, i_code} << n_fill);
        n_mask   = WINDOW_BITS'((32'd1 << n_fill) - 32'd1);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_len_ok   <= n_len_ok;
            r_base     <= n_base;
            r_mask     <= n_mask;
            r_find_idx <= i_code[hclt_pkg::CODE_W-1 -: WINDOW_BITS];
            r_len      <= i_code_length;
            r_sym      <= i_symbol;
        end
        if (i_cmd.rd_first) begin
            r_cnt <= '0;
        end else if (i_cmd.fill) begin
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.res_find) begin
            r_pend_status <= rdata[hclt_pkg::ENTRY_W-1] ? hclt_pkg::STATUS_OK
                                                         : hclt_pkg::STATUS_FAIL;
            r_pend_len    <= rdata[hclt_pkg::ENTRY_W-1] ? rdata[hclt_pkg::SYM_W +:
                                                               hclt_pkg::LEN_W] : '0;
            r_pend_sym    <= rdata[hclt_pkg::ENTRY_W-1] ? rdata[hclt_pkg::SYM_W-1:0]
                                                         : '0;
        end else if (i_cmd.res_fail || i_cmd.res_ok) begin
            r_pend_status <= i_cmd.res_fail ? hclt_pkg::STATUS_FAIL
                                            : hclt_pkg::STATUS_OK;
            r_pend_len    <= '0;
            r_pend_sym    <= '0;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_pend_status;
            r_out_len    <= r_pend_len;
            r_out_sym    <= r_pend_sym;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Write port: clearing sweep or fill; read port runs one entry ahead of the fill.
    always_comb begin
        we    = i_cmd.clr || i_cmd.fill;
        waddr = i_cmd.clr ? r_clr_cnt : (r_base | r_cnt);
        wdata = i_cmd.clr ? '0 : {1'b1, r_len, r_sym};
        if (i_cmd.rd_first) begin
            raddr = r_base;
        end else if (i_cmd.fill) begin
            raddr = r_base | (r_cnt + 1'b1);
        end else begin
            raddr = r_find_idx;
        end
    end

    hclt_ram #(
        .WIDTH (hclt_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        o_sts.clr_last  = &r_clr_cnt;
        o_sts.len_ok    = r_len_ok;
        o_sts.hit       = rdata[hclt_pkg::ENTRY_W-1];
        o_sts.fill_last = (r_cnt == r_mask);
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_matched_length = r_out_len;
    assign o_matched_symbol = r_out_sym;

endmodule

### hw/rtl/hclt_ctrl.sv
// Controller: clearing sweep, find and add sequencing, result handoff.
module hclt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_action,
    output logic           o_ready,
    input  hclt_pkg::t_sts i_sts,
    output hclt_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_FIND  = 3'd2;
    localparam logic [2:0] S_FRES  = 3'd3;
    localparam logic [2:0] S_ADD   = 3'd4;
    localparam logic [2:0] S_FILL  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = (i_action == hclt_pkg::ACT_FIND) ? S_FIND : S_ADD;
                end
            end
            S_FIND: begin
                o_cmd.rd_find = 1'b1;
                n_state       = S_FRES;
            end
            S_FRES: begin
                o_cmd.res_find = 1'b1;
                n_state        = S_OUT;
            end
            S_ADD: begin
                if (!i_sts.len_ok) begin
                    o_cmd.res_fail = 1'b1;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.rd_first = 1'b1;
                    n_state        = S_FILL;
                end
            end
            S_FILL: begin
                if (i_sts.hit) begin
                    o_cmd.res_fail = 1'b1;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.fill = 1'b1;
                    if (i_sts.fill_last) begin
                        o_cmd.res_ok = 1'b1;
                        n_state      = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/huffman_code_lookup_table_top.sv
// Top level of the flat Huffman code lookup table.
//
// Input channel (i_valid/o_ready): one request of i_action, i_code,
// i_code_length, i_symbol. Add (action 0) fills every window entry that
// starts with the right-aligned code; find (action 1) reads the entry at
// the top WINDOW_BITS bits of i_code.
// Output channel (o_valid/i_ready): one result per request, o_status,
// o_matched_length, o_matched_symbol.
// A find reads the entry in its read state and registers it in its result
// state before it loads the result register. An add checks the length, then
// fills up to 2^(WINDOW_BITS-length) entries, with the single table memory
// port pair doing one read and one write a cycle; an add that meets an
// occupied entry stops there and fails. A rejected add goes from its length
// check straight to the result. The next request can be taken in the cycle
// after the result is loaded. After reset a clearing sweep writes every one
// of the 2^WINDOW_BITS entries (65536 by default) empty, with o_ready low.
// A stalled receiver holds the result in the output register; a finished
// request then waits for the register to free before the next one is taken.
module huffman_code_lookup_table_top #(
    parameter int WINDOW_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_action,
    input  logic [hclt_pkg::CODE_W-1:0] i_code,
    input  logic [hclt_pkg::LEN_W-1:0]  i_code_length,
    input  logic [hclt_pkg::SYM_W-1:0]  i_symbol,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_status,
    output logic [hclt_pkg::LEN_W-1:0]  o_matched_length,
    output logic [hclt_pkg::SYM_W-1:0]  o_matched_symbol
);

    hclt_pkg::t_cmd cmd;
    hclt_pkg::t_sts sts;

    hclt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .o_ready  (o_ready),
        .i_sts    (sts),
        .o_cmd    (cmd)
    );

    hclt_dp #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_code           (i_code),
        .i_code_length    (i_code_length),
        .i_symbol         (i_symbol),
        .i_out_ready      (i_ready),
        .o_out_valid      (o_valid),
        .o_status         (o_status),
        .o_matched_length (o_matched_length),
        .o_matched_symbol (o_matched_symbol)
    );

endmodule

### test/huffman_code_lookup_table_top_test.sv
// Self-checking testbench for the flat Huffman code lookup table top level.
module huffman_code_lookup_table_top_test;

    localparam int   CODE_W      = hclt_pkg::CODE_W;
    localparam int   LEN_W       = hclt_pkg::LEN_W;
    localparam int   SYM_W       = hclt_pkg::SYM_W;
    localparam logic ACT_ADD     = hclt_pkg::ACT_ADD;
    localparam logic ACT_FIND    = hclt_pkg::ACT_FIND;
    localparam logic STATUS_OK   = hclt_pkg::STATUS_OK;
    localparam logic STATUS_FAIL = hclt_pkg::STATUS_FAIL;

    localparam int WINDOW_BITS      = 16;
    localparam int TABLE_SIZE       = 1 << WINDOW_BITS;
    localparam int INDEX_MASK       = TABLE_SIZE - 1;
    localparam int DIRECTED_N       = 25;
    localparam int RANDOM_PER_PHASE = 459;
    localparam int CYCLE_LIMIT      = 1_000_000;

    typedef struct packed {
        logic             act;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
        logic [SYM_W-1:0]  sym;
    } t_request;

    typedef struct packed {
        logic             status;
        logic [LEN_W-1:0] len;
        logic [SYM_W-1:0] sym;
    } t_lookup_result;

    typedef struct packed {
        logic             used;
        logic [LEN_W-1:0] len;
        logic [SYM_W-1:0] sym;
    } t_slot;

    typedef struct packed {
        t_request       rq;
        logic           typed;
        t_lookup_result res;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    logic i_action;
    logic [CODE_W-1:0] i_code;
    logic [LEN_W-1:0]  i_code_length;
    logic [SYM_W-1:0]  i_symbol;
    logic o_valid;
    logic i_ready = 1'b0;
    logic o_status;
    logic [LEN_W-1:0]  o_matched_length;
    logic [SYM_W-1:0]  o_matched_symbol;

    t_slot          decode_slots [TABLE_SIZE];
    t_lookup_result pending_results [$];
    logic [CODE_W-1:0] added_codes [$];
    logic [LEN_W-1:0]  added_lens [$];
    t_lookup_result due;
    int mismatch_count = 0;
    int cycle_count = 0;
    int send_gap_pct = 0;
    int recv_hold_pct = 0;

    t_stim_row directed_rows [DIRECTED_N] = '{
        '{'{ACT_FIND, 16'h0000, 5'd0,  8'h00}, 1'b1, '{STATUS_FAIL, 5'd0,  8'h00}},
        '{'{ACT_FIND, 16'hFFFF, 5'd31, 8'hFF}, 1'b1, '{STATUS_FAIL, 5'd0,  8'h00}},
        '{'{ACT_ADD,  16'hFFFF, 5'd16, 8'hFF}, 1'b1, '{STATUS_OK,   5'd0,  8'h00}},
        '{'{ACT_FIND, 16'hFFFF, 5'd0,  8'h00}, 1'b1, '{STATUS_OK,   5'd16, 8'hFF}},
        '{'{ACT_ADD,  16'hFFFF, 5'd16, 8'h00}, 1'b1, '{STATUS_FAIL, 5'd0,  8'h00}},
        '{'{ACT_ADD,  16'h1234, 5'd0,  8'h5A}, 1'b1, '{STATUS_FAIL, 5'd0,  8'h00}},
        '{'{ACT_ADD,  16'h0000, 5'd17, 8'h00}, 1'b1, '{STATUS_FAIL, 5'd0,  8'h00}},
        '{'{ACT_ADD,  16'hFFFF, 5'd31, 8'hFF}, 1'b1, '{STATUS_FAIL, 5'd0,  8'h00}},
        '{'{ACT_ADD,  16'hFFFF, 5'd1,  8'hA5}, 1'b0, '{STATUS_OK,   5'd0,  8'h00}},
        '{'{ACT_FIND, 16'h8000, 5'd1,  8'h00}, 1'b0, '{STATUS_OK,   5'd0,  8'h00}},
        '{'{ACT_FIND, 16'hFFFE, 5'd0,  8'hFF}, 1'b0, '{STATUS_OK,   5'd0,  8'h00}},
        '{'{ACT_FIND, 16'hFFFF, 5'd0,  8'h00}, 1'b1, '{STATUS_OK,   5'd16, 8'hFF}},
        '{'{ACT_ADD,  16'h0000, 5'd16, 8'h00}, 1'b1, '{STATUS_OK,   5'd0,  8'h00}},
        '{'{ACT_ADD,  16'h0000, 5'd4,  8'h3C}, 1'b1, '{STATUS_FAIL, 5'd0,  8'h00}},
        '{'{ACT_ADD,  16'h0105, 5'd16, 8'h11}, 1'b0, '{STATUS_OK,   5'd0,  8'h00}},
        '{'{ACT_ADD,  16'hFF01, 5'd8,  8'h22}, 1'b0, '{STATUS_OK,   5'd0,  8'h00}},
        '{'{ACT_FIND, 16'h0104, 5'd8,  8'h22}, 1'b0, '{STATUS_OK,   5'd0,  8'h00}},
        '{'{ACT_FIND, 16'h0106, 5'd0,  8'h00}, 1'b0, '{STATUS_OK,   5'd0,  8'h00}},
        '{'{ACT_ADD,  16'h7FFF, 5'd15, 8'h77}, 1'b0, '{STATUS_OK,   5'd0,  8'h00}},
        '{'{ACT_ADD,  16'h1234, 5'd15, 8'h80}, 1'b0, '{STATUS_OK,   5'd0,  8'h00}},
        '{'{ACT_FIND, 16'h2469, 5'd0,  8'h00}, 1'b0, '{STATUS_OK,   5'd0,  8'h00}},
        '{'{ACT_ADD,  16'hFFF9, 5'd3,  8'h33}, 1'b0, '{STATUS_OK,   5'd0,  8'h00}},
        '{'{ACT_FIND, 16'h2000, 5'd0,  8'h00}, 1'b0, '{STATUS_OK,   5'd0,  8'h00}},
        '{'{ACT_FIND, 16'h2468, 5'd0,  8'h00}, 1'b0, '{STATUS_OK,   5'd0,  8'h00}},
        '{'{ACT_FIND, 16'h7FFF, 5'd31, 8'hFF}, 1'b0, '{STATUS_OK,   5'd0,  8'h00}}
    };

    huffman_code_lookup_table_top #(
        .WINDOW_BITS(WINDOW_BITS)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_action        (i_action),
        .i_code          (i_code),
        .i_code_length   (i_code_length),
        .i_symbol        (i_symbol),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_matched_length(o_matched_length),
        .o_matched_symbol(o_matched_symbol)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic t_lookup_result decode_table_apply(t_request rq);
        t_lookup_result res;
        int unsigned idx;
        int unsigned fill;
        int unsigned prefix;
        int unsigned base;
        int unsigned count;
        res = '{STATUS_FAIL, '0, '0};
        if (rq.act == ACT_FIND) begin
            idx = (32'(rq.code) >> (16 - WINDOW_BITS)) & INDEX_MASK;
            if (decode_slots[idx].used) begin
                res.status = STATUS_OK;
                res.len    = decode_slots[idx].len;
                res.sym    = decode_slots[idx].sym;
            end
            return res;
        end
        if (rq.len == 0 || rq.len > WINDOW_BITS)
            return res;
        fill   = WINDOW_BITS - rq.len;
        prefix = 32'(rq.code) & ((32'd1 << rq.len) - 1);
        base   = (prefix << fill) & INDEX_MASK;
        count  = 32'd1 << fill;
        for (int unsigned i = 0; i < count; i++) begin
            idx = (base | i) & INDEX_MASK;
            if (decode_slots[idx].used)
                return res;
            decode_slots[idx] = '{1'b1, rq.len, rq.sym};
        end
        res.status = STATUS_OK;
        return res;
    endfunction

    // Result channel: random back-pressure and in-order compare.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_hold_pct);
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none pending: status %0d length %0d symbol %0h",
                         $time, o_status, o_matched_length, o_matched_symbol);
                mismatch_count++;
            end else begin
                due = pending_results.pop_front();
                if (o_status !== due.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, due.status, o_status);
                    mismatch_count++;
                end
                if (o_matched_length !== due.len) begin
                    $display("%0t: matched_length expected %0d actual %0d",
                             $time, due.len, o_matched_length);
                    mismatch_count++;
                end
                if (o_matched_symbol !== due.sym) begin
                    $display("%0t: matched_symbol expected %0h actual %0h",
                             $time, due.sym, o_matched_symbol);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic pace_sender();
        while ($urandom_range(0, 99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        if (pending_results.size() != 0) begin
            i_valid <= 1'b0;
            while (pending_results.size() != 0)
                @(posedge i_clk);
        end
    endtask

    task automatic issue_request(input t_request rq, input logic typed,
                                 input t_lookup_result typed_res);
        t_lookup_result predicted;
        i_valid       <= 1'b1;
        i_action      <= rq.act;
        i_code        <= rq.code;
        i_code_length <= rq.len;
        i_symbol      <= rq.sym;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        predicted = decode_table_apply(rq);
        pending_results.push_back(typed ? typed_res : predicted);
        if (rq.act == ACT_ADD && rq.len >= 1 && rq.len <= WINDOW_BITS) begin
            added_codes.push_back(rq.code);
            added_lens.push_back(rq.len);
        end
    endtask

    // Mostly adds with long codes and finds aimed at codes already added.
    task automatic build_random_request(output t_request rq);
        int pick;
        int roll;
        int k;
        int unsigned prefix;
        int unsigned low_bits;
        pick = $urandom_range(0, 99);
        rq.code = CODE_W'($urandom);
        rq.len  = LEN_W'($urandom);
        rq.sym  = SYM_W'($urandom);
        if (pick < 40) begin
            rq.act = ACT_ADD;
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                rq.len = LEN_W'($urandom_range(5, 8));
            end else if (roll < 8) begin
                k = $urandom_range(0, 15);
                rq.len = (k == 0) ? LEN_W'(0) : LEN_W'(16 + k);
            end else if (roll < 12 && added_codes.size() != 0) begin
                k = $urandom_range(0, added_codes.size() - 1);
                rq.code = added_codes[k];
                rq.len  = added_lens[k];
            end else begin
                rq.len = LEN_W'($urandom_range(9, 16));
            end
        end else if (pick < 85 && added_codes.size() != 0) begin
            rq.act = ACT_FIND;
            k = $urandom_range(0, added_codes.size() - 1);
            prefix   = 32'(added_codes[k]) & ((32'd1 << added_lens[k]) - 1);
            low_bits = $urandom & ((32'd1 << (16 - added_lens[k])) - 1);
            rq.code  = CODE_W'((prefix << (16 - added_lens[k])) | low_bits);
        end else begin
            rq.act = ACT_FIND;
        end
    endtask

    initial begin
        t_request rq;
        foreach (decode_slots[i])
            decode_slots[i] = '0;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_action      <= ACT_ADD;
        i_code        <= '0;
        i_code_length <= '0;
        i_symbol      <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_gap_pct  = 18;
                    recv_hold_pct = 58;
                end
                1: begin
                    send_gap_pct  = 58;
                    recv_hold_pct = 18;
                end
                default: begin
                    send_gap_pct  = 0;
                    recv_hold_pct = 0;
                end
            endcase
            drain_results();
            if (phase == 0) begin
                for (int r = 0; r < DIRECTED_N; r++) begin
                    pace_sender();
                    issue_request(directed_rows[r].rq, directed_rows[r].typed,
                                  directed_rows[r].res);
                end
                drain_results();
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                build_random_request(rq);
                pace_sender();
                issue_request(rq, 1'b0, '0);
            end
        end

        drain_results();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/hclt_pkg.sv
hw/rtl/hclt_ram.sv
hw/rtl/hclt_dp.sv
hw/rtl/hclt_ctrl.sv
hw/rtl/huffman_code_lookup_table_top.sv
test/huffman_code_lookup_table_top_test.sv
